@@ rtl/core/elevation_grid_min_max_binning_defines.svh @@
// Assertion macros shared by the elevation grid checker.
`ifndef ELEVATION_GRID_MIN_MAX_BINNING_DEFINES_SVH
`define ELEVATION_GRID_MIN_MAX_BINNING_DEFINES_SVH

// Concurrent check, masked while reset is high.
`define EGMMB_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define EGMMB_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/egmmb_pkg.sv @@
// Shared types and codes for the elevation grid binning block.
package egmmb_pkg;

  // Item commands
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_CORNER_X = 2'd0;
  localparam logic [1:0] REG_CORNER_Y = 2'd1;
  localparam logic [1:0] REG_INV_CELL = 2'd2;

  localparam logic [23:0] INV_CELL_RESET = 24'd83886;

  // One stored cell
  typedef struct packed {
    logic              valid;
    logic signed [23:0] low;
    logic signed [23:0] high;
  } cell_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

endpackage

@@ rtl/core/elevation_grid_min_max_binning.sv @@
// Elevation grid min/max binning: top level with cell memory and update pipeline.
//
// Usage: an item (cmd, point_x/y/z, cell_row_in, cell_col_in) transfers at a
// rising edge with start high and busy low. cmd insert maps x,y to a cell
// through the corner registers and the Q24 reciprocal, then folds point_z
// into the cell's low/high; read reports a cell; clear empties it.
// Every item gives one result: done is high for one cycle with in_map,
// cell_row, cell_col, cell_valid, low_z, high_z and height_span. The
// receiver cannot hold results off; they must be taken that cycle.
// Pipeline: an item passes the subtract, multiply, memory read and update
// stages before done rises. One item per cycle is accepted back to back
// while busy is low; the cell memory is read one stage ahead of the
// write-back, and the entry written in the previous cycle is forwarded.
// Reset: registers go to their reset values and a clearing pass writes
// all 2^(clog2(GRID_ROWS) + clog2(GRID_COLS)) memory words (65536 at the
// defaults) empty, one word per cycle, with busy high.
// Register writes are taken during the pass as well.
module elevation_grid_min_max_binning
  import egmmb_pkg::*;
#(
  parameter int GRID_ROWS = 256,
  parameter int GRID_COLS = 256
) (
  input  logic               clk,
  input  logic               rst,
  // item channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic signed [23:0] point_x,
  input  logic signed [23:0] point_y,
  input  logic signed [23:0] point_z,
  input  logic [7:0]         cell_row_in,
  input  logic [7:0]         cell_col_in,
  // result channel
  output logic               done,
  output logic               in_map,
  output logic [7:0]         cell_row,
  output logic [7:0]         cell_col,
  output logic               cell_valid,
  output logic signed [23:0] low_z,
  output logic signed [23:0] high_z,
  output logic [23:0]        height_span,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;

  // configuration
  logic signed [23:0] corner_x;
  logic signed [23:0] corner_y;
  logic [23:0]        inv_cell_size;

  state_t        state;
  logic [AW-1:0] clr_cnt;

  // stage A: offsets
  logic               a_vld;
  logic [1:0]         a_cmd;
  logic signed [24:0] a_dx;
  logic signed [24:0] a_dy;
  logic signed [23:0] a_z;
  logic [7:0]         a_row_in;
  logic [7:0]         a_col_in;

  // stage B: scaled offsets
  logic               b_vld;
  logic [1:0]         b_cmd;
  logic               b_neg;
  logic [23:0]        b_colp;
  logic [23:0]        b_rowp;
  logic signed [23:0] b_z;
  logic [7:0]         b_row_in;
  logic [7:0]         b_col_in;

  // stage C: memory read issued
  logic               c_vld;
  logic [1:0]         c_cmd;
  logic               c_ok;
  logic [7:0]         c_row8;
  logic [7:0]         c_col8;
  logic [AW-1:0]      c_addr;
  logic signed [23:0] c_z;

  // memory
  cell_t         mem [0:DEPTH-1];
  cell_t         rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  cell_t         wr_data;

  // last write, for the read issued on the same edge
  logic          fwd_en;
  logic [AW-1:0] fwd_addr;
  cell_t         fwd_data;

  logic [47:0] prod_x;
  logic [47:0] prod_y;
  logic [23:0] row_sel;
  logic [23:0] col_sel;
  logic        ok_sel;
  cell_t       cur;
  cell_t       upd;
  logic        upd_wr;
  logic        accept;
  logic        cfg_wr;

  assign busy   = (state == ST_CLEAR);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // register port
  always_ff @(posedge clk) begin
    if (rst) begin
      corner_x      <= '0;
      corner_y      <= '0;
      inv_cell_size <= INV_CELL_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CORNER_X: corner_x      <= pwdata[23:0];
        REG_CORNER_Y: corner_y      <= pwdata[23:0];
        REG_INV_CELL: inv_cell_size <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CORNER_X: prdata = {{8{corner_x[23]}}, corner_x};
      REG_CORNER_Y: prdata = {{8{corner_y[23]}}, corner_y};
      REG_INV_CELL: prdata = {8'd0, inv_cell_size};
      default:      prdata = '0;
    endcase
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == {AW{1'b1}}) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: ;
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // stage A
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    a_cmd    <= cmd;
    a_dx     <= {point_x[23], point_x} - {corner_x[23], corner_x};
    a_dy     <= {point_y[23], point_y} - {corner_y[23], corner_y};
    a_z      <= point_z;
    a_row_in <= cell_row_in;
    a_col_in <= cell_col_in;
  end

  // stage B: Q24 scale
  assign prod_x = {24'd0, a_dx[23:0]} * {24'd0, inv_cell_size};
  assign prod_y = {24'd0, a_dy[23:0]} * {24'd0, inv_cell_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    b_cmd    <= a_cmd;
    b_neg    <= a_dx[24] || a_dy[24];
    b_colp   <= prod_x[47:24];
    b_rowp   <= prod_y[47:24];
    b_z      <= a_z;
    b_row_in <= a_row_in;
    b_col_in <= a_col_in;
  end

  // stage C: range check and address
  always_comb begin
    if (b_cmd == CMD_INSERT) begin
      row_sel = b_rowp;
      col_sel = b_colp;
    end else begin
      row_sel = {16'd0, b_row_in};
      col_sel = {16'd0, b_col_in};
    end
    case (b_cmd)
      CMD_INSERT: ok_sel = !b_neg && (row_sel < 24'(GRID_ROWS)) && (col_sel < 24'(GRID_COLS));
      CMD_READ,
      CMD_CLEAR:  ok_sel = (row_sel < 24'(GRID_ROWS)) && (col_sel < 24'(GRID_COLS));
      default:    ok_sel = 1'b0;
    endcase
    rd_addr = {row_sel[RW-1:0], col_sel[CW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    c_cmd  <= b_cmd;
    c_ok   <= ok_sel;
    c_row8 <= row_sel[7:0];
    c_col8 <= col_sel[7:0];
    c_addr <= rd_addr;
    c_z    <= b_z;
  end

  // stage D: modify and write back
  always_comb begin
    if (fwd_en && (fwd_addr == c_addr)) begin
      cur = fwd_data;
    end else begin
      cur = rd_data;
    end
    upd    = cur;
    upd_wr = 1'b0;
    case (c_cmd)
      CMD_INSERT: begin
        upd_wr     = 1'b1;
        upd.valid  = 1'b1;
        if (!cur.valid || (c_z < cur.low)) begin
          upd.low = c_z;
        end
        if (!cur.valid || (c_z > cur.high)) begin
          upd.high = c_z;
        end
      end
      CMD_CLEAR: begin
        upd_wr    = 1'b1;
        upd.valid = 1'b0;
      end
      default: ;
    endcase

    if (busy) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = '0;
    end else begin
      wr_en   = c_vld && c_ok && upd_wr;
      wr_addr = c_addr;
      wr_data = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_en <= 1'b0;
    end else begin
      fwd_en <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= wr_addr;
    fwd_data <= wr_data;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    in_map      <= c_ok;
    cell_row    <= c_ok ? c_row8 : 8'd0;
    cell_col    <= c_ok ? c_col8 : 8'd0;
    cell_valid  <= c_ok && upd.valid;
    if (c_ok && upd.valid) begin
      low_z       <= upd.low;
      high_z      <= upd.high;
      height_span <= upd.high - upd.low;
    end else begin
      low_z       <= '0;
      high_z      <= '0;
      height_span <= '0;
    end
  end

endmodule

@@ rtl/core/egmmb_checker.sv @@
// Port-level checker for the elevation grid binning block, with its bind.
`include "elevation_grid_min_max_binning_defines.svh"

module egmmb_assertions (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               in_map,
  input logic [7:0]         cell_row,
  input logic [7:0]         cell_col,
  input logic               cell_valid,
  input logic signed [23:0] low_z,
  input logic signed [23:0] high_z,
  input logic [23:0]        height_span
);

  logic xfer;
  logic zero_fields;
  logic span_ok;

  assign xfer        = start && !busy;
  assign zero_fields = !cell_valid && (cell_row == 8'd0) && (cell_col == 8'd0) &&
                       (low_z == 24'sd0) && (high_z == 24'sd0) && (height_span == 24'd0);
  assign span_ok     = (low_z <= high_z) && (height_span == 24'(high_z - low_z));

  `EGMMB_ASSERT(a_latency, clk, rst, xfer |-> ##4 done, "result missing after transfer")
  `EGMMB_ASSERT(a_no_spurious, clk, rst, done |-> $past(xfer, 4), "result without transfer")
  `EGMMB_ASSERT(a_off_grid_zero, clk, rst, (done && !in_map) |-> zero_fields, "off-grid nonzero")
  `EGMMB_ASSERT(a_span, clk, rst, (done && cell_valid) |-> span_ok, "span mismatch")
  `EGMMB_ASSERT_ALWAYS(a_clear_after_rst, clk, rst |=> busy, "busy low after reset")

endmodule

bind elevation_grid_min_max_binning egmmb_assertions u_egmmb_assertions (.*);

@@ verif/egmmb_checker.sv @@
// Result checker for the elevation grid binning block: tracks cell contents and compares reports.
module egmmb_checker
  import egmmb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         cmd,
  input  logic signed [23:0] point_x,
  input  logic signed [23:0] point_y,
  input  logic signed [23:0] point_z,
  input  logic [7:0]         cell_row_in,
  input  logic [7:0]         cell_col_in,
  input  logic               done,
  input  logic               in_map,
  input  logic [7:0]         cell_row,
  input  logic [7:0]         cell_col,
  input  logic               cell_valid,
  input  logic signed [23:0] low_z,
  input  logic signed [23:0] high_z,
  input  logic [23:0]        height_span,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 mismatches,
  output int                 outstanding,
  output int                 reports_seen,
  output int                 filled_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = 256;
  localparam int COLS = 256;

  typedef struct packed {
    logic               in_map;
    logic [7:0]         row;
    logic [7:0]         col;
    logic               valid;
    logic signed [23:0] low;
    logic signed [23:0] high;
    logic [23:0]        span;
  } cell_report_t;

  logic signed [23:0] corner_x_mm;
  logic signed [23:0] corner_y_mm;
  logic [23:0]        inv_cell_q24;
  logic               occupied [ROWS*COLS];
  logic signed [23:0] lowest_mm [ROWS*COLS];
  logic signed [23:0] highest_mm [ROWS*COLS];
  cell_report_t       expected_reports [$];

  task automatic log_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [23:0] got, input logic [23:0] want);
    if (got !== want) begin
      log_error($sformatf("%s got %h, want %h", name, got, want));
    end
  endtask

  function automatic cell_report_t cell_view(int row, int col);
    cell_report_t rep;
    int addr;
    addr = row * COLS + col;
    rep = '0;
    rep.in_map = 1'b1;
    rep.row = row[7:0];
    rep.col = col[7:0];
    if (occupied[addr]) begin
      rep.valid = 1'b1;
      rep.low = lowest_mm[addr];
      rep.high = highest_mm[addr];
      rep.span = highest_mm[addr] - lowest_mm[addr];
    end
    return rep;
  endfunction

  // Applies one item to the tracked grid and returns the report it should produce.
  function automatic cell_report_t bin_item(logic [1:0] op, logic signed [23:0] px, py, pz,
                                            logic [7:0] r_in, c_in);
    cell_report_t rep;
    longint dx, dy, row, col;
    int addr;
    rep = '0;
    case (op)
      CMD_INSERT: begin
        dx = longint'(px) - longint'(corner_x_mm);
        dy = longint'(py) - longint'(corner_y_mm);
        if (dx >= 0 && dy >= 0) begin
          col = (dx * longint'(inv_cell_q24)) >>> 24;
          row = (dy * longint'(inv_cell_q24)) >>> 24;
          if (row < ROWS && col < COLS) begin
            addr = int'(row) * COLS + int'(col);
            if (!occupied[addr]) begin
              occupied[addr] = 1'b1;
              lowest_mm[addr] = pz;
              highest_mm[addr] = pz;
            end else begin
              if (pz < lowest_mm[addr]) lowest_mm[addr] = pz;
              if (pz > highest_mm[addr]) highest_mm[addr] = pz;
            end
            rep = cell_view(int'(row), int'(col));
          end
        end
      end
      CMD_READ, CMD_CLEAR: begin
        if (r_in < ROWS && c_in < COLS) begin
          if (op == CMD_CLEAR) occupied[r_in * COLS + c_in] = 1'b0;
          rep = cell_view(r_in, c_in);
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  always @(posedge clk) begin
    cell_report_t want;
    if (rst) begin
      corner_x_mm = '0;
      corner_y_mm = '0;
      inv_cell_q24 = INV_CELL_RESET;
      foreach (occupied[i]) occupied[i] = 1'b0;
      expected_reports.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_CORNER_X: corner_x_mm = pwdata[23:0];
          REG_CORNER_Y: corner_y_mm = pwdata[23:0];
          REG_INV_CELL: inv_cell_q24 = pwdata[23:0];
          default: ;
        endcase
      end
      if (done) begin
        if (expected_reports.size() == 0) begin
          log_error("result transfer with no item waiting");
        end else begin
          want = expected_reports.pop_front();
          check_field("in_map", in_map, want.in_map);
          check_field("cell_row", cell_row, want.row);
          check_field("cell_col", cell_col, want.col);
          check_field("cell_valid", cell_valid, want.valid);
          check_field("low_z", low_z, want.low);
          check_field("high_z", high_z, want.high);
          check_field("height_span", height_span, want.span);
          reports_seen++;
          if (want.valid) filled_seen++;
        end
      end
      if (start && !busy) begin
        expected_reports.push_back(bin_item(cmd, point_x, point_y, point_z,
                                            cell_row_in, cell_col_in));
      end
    end
    outstanding <= expected_reports.size();
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for the elevation grid binning block: reset, register setups and item traffic.
module tb_top
  import egmmb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 240;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         cmd;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic signed [23:0] point_z;
  logic [7:0]         cell_row_in;
  logic [7:0]         cell_col_in;
  logic               done;
  logic               in_map;
  logic [7:0]         cell_row;
  logic [7:0]         cell_col;
  logic               cell_valid;
  logic signed [23:0] low_z;
  logic signed [23:0] high_z;
  logic [23:0]        height_span;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int mismatches;
  int outstanding;
  int reports_seen;
  int filled_seen;
  int cycles;
  int sent_by_op [4];
  int setups_loaded;

  // current grid placement, used only to aim points into a window of cells
  int          grid_x0;
  int          grid_y0;
  int unsigned grid_inv;
  int unsigned cell_mm;
  int          window_row;
  int          window_col;

  elevation_grid_min_max_binning i_dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .cmd(cmd),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .cell_row_in(cell_row_in), .cell_col_in(cell_col_in),
    .done(done), .in_map(in_map), .cell_row(cell_row), .cell_col(cell_col),
    .cell_valid(cell_valid), .low_z(low_z), .high_z(high_z), .height_span(height_span),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  egmmb_checker i_checker (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .cmd(cmd),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .cell_row_in(cell_row_in), .cell_col_in(cell_col_in),
    .done(done), .in_map(in_map), .cell_row(cell_row), .cell_col(cell_col),
    .cell_valid(cell_valid), .low_z(low_z), .high_z(high_z), .height_span(height_span),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .outstanding(outstanding),
    .reports_seen(reports_seen), .filled_seen(filled_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("elevation_grid_min_max_binning test failed");
      $finish;
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [23:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{8{value[23]}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_grid_setup(input int cx, input int cy, input logic [23:0] inv);
    apb_write(REG_CORNER_X, cx[23:0]);
    apb_write(REG_CORNER_Y, cy[23:0]);
    apb_write(REG_INV_CELL, inv);
    grid_x0 = cx;
    grid_y0 = cy;
    grid_inv = inv;
    setups_loaded++;
  endtask

  // Holds the item on the channel until the block takes it.
  task automatic send_item(input logic [1:0] op, input logic [23:0] x, y, z,
                           input logic [7:0] r, c);
    start <= 1'b1;
    cmd <= op;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    cell_row_in <= r;
    cell_col_in <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_by_op[op]++;
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 7)) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Position inside one of the 8 cells starting at base_cell, sometimes pushed back past the edge.
  function automatic logic [23:0] aim_at(int origin, int base_cell);
    longint pos;
    pos = longint'(origin) + longint'(base_cell + int'($urandom_range(0, 7))) * cell_mm
          + longint'($urandom_range(0, cell_mm - 1));
    if ($urandom_range(0, 7) == 0) pos -= longint'($urandom_range(0, 2 * cell_mm));
    if (pos > 8388607) pos = 8388607;
    if (pos < -8388608) pos = -8388608;
    return pos[23:0];
  endfunction

  task automatic random_item();
    logic [1:0]  op;
    logic [23:0] x, y, z;
    logic [7:0]  r, c;
    int          pick;
    pick = $urandom_range(0, 99);
    x = 24'($urandom);
    y = 24'($urandom);
    z = 24'($urandom);
    r = 8'($urandom);
    c = 8'($urandom);
    if (pick < 58) begin
      op = CMD_INSERT;
      x = aim_at(grid_x0, window_col);
      y = aim_at(grid_y0, window_row);
      if ($urandom_range(0, 3) == 0) z = 24'($urandom_range(0, 40)) - 24'd20;
    end else if (pick < 66) begin
      op = CMD_INSERT;
    end else if (pick < 84) begin
      op = CMD_READ;
      if (pick < 80) begin
        r = 8'(window_row + $urandom_range(0, 7));
        c = 8'(window_col + $urandom_range(0, 7));
      end
    end else if (pick < 95) begin
      op = CMD_CLEAR;
      if (pick < 93) begin
        r = 8'(window_row + $urandom_range(0, 7));
        c = 8'(window_col + $urandom_range(0, 7));
      end
    end else begin
      op = CMD_UNUSED;
    end
    send_item(op, x, y, z, r, c);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_INSERT;
    point_x = '0;
    point_y = '0;
    point_z = '0;
    cell_row_in = '0;
    cell_col_in = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    setups_loaded = 1;
    grid_x0 = 0;
    grid_y0 = 0;
    grid_inv = INV_CELL_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset placement, 200 mm cells from the origin
    send_item(CMD_INSERT, 24'd0, 24'd0, 24'd0, 8'd0, 8'd0);
    send_item(CMD_INSERT, 24'd0, 24'd0, 24'h7FFFFF, 8'd0, 8'd0);
    send_item(CMD_INSERT, 24'd0, 24'd0, 24'h800000, 8'd0, 8'd0);
    send_item(CMD_READ, 24'd0, 24'd0, 24'd0, 8'd0, 8'd0);
    send_item(CMD_INSERT, 24'hFFFFFF, 24'd100, 24'd5, 8'd0, 8'd0);
    send_item(CMD_INSERT, 24'd100, 24'hFFFFFF, 24'd5, 8'd0, 8'd0);
    send_item(CMD_INSERT, 24'h7FFFFF, 24'h7FFFFF, 24'd1, 8'd0, 8'd0);
    send_item(CMD_INSERT, 24'h800000, 24'h800000, 24'd1, 8'd0, 8'd0);
    send_item(CMD_INSERT, 24'd51199, 24'd51199, -24'sd7, 8'd0, 8'd0);
    send_item(CMD_INSERT, 24'd51000, 24'd51000, 24'd9, 8'd0, 8'd0);
    send_item(CMD_INSERT, 24'd51000, 24'd51000, -24'sd9, 8'd0, 8'd0);
    send_item(CMD_INSERT, 24'd51300, 24'd100, 24'd3, 8'd0, 8'd0);
    send_item(CMD_READ, 24'd0, 24'd0, 24'd0, 8'd255, 8'd255);
    send_item(CMD_READ, 24'd0, 24'd0, 24'd0, 8'd254, 8'd254);
    send_item(CMD_CLEAR, 24'd0, 24'd0, 24'd0, 8'd0, 8'd0);
    send_item(CMD_READ, 24'd0, 24'd0, 24'd0, 8'd0, 8'd0);
    send_item(CMD_CLEAR, 24'd0, 24'd0, 24'd0, 8'd255, 8'd255);
    send_item(CMD_READ, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'd200, 8'd17);
    send_item(CMD_UNUSED, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'd255, 8'd255);
    send_item(CMD_UNUSED, 24'd0, 24'd0, 24'd0, 8'd0, 8'd0);
    send_item(CMD_INSERT, 24'd199, 24'd200, 24'd42, 8'd0, 8'd0);
    send_item(CMD_READ, 24'd0, 24'd0, 24'd0, 8'd1, 8'd0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: ;
        1: load_grid_setup(-8388608, 8388607, 24'hFFFFFF);
        2: load_grid_setup(-1000, 2000, 24'd0);
        3: load_grid_setup(-8388608, -8388608, 24'd1);
        default: load_grid_setup(int'($urandom_range(0, 4000000)) - 2000000,
                                 int'($urandom_range(0, 4000000)) - 2000000,
                                 24'((1 << 24) / $urandom_range(1, 1000)));
      endcase
      if (grid_inv == 0) cell_mm = 1 << 24;
      else cell_mm = ((1 << 24) / grid_inv > 0) ? (1 << 24) / grid_inv : 1;
      window_row = $urandom_range(0, 248);
      window_col = $urandom_range(0, 248);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        random_item();
        // the last phase runs back to back
        if (p < PHASES - 1 && $urandom_range(0, 4) == 0) idle_burst();
      end
      settle();
    end

    $display("sent %0d inserts, %0d reads, %0d clears, %0d unused commands over %0d grid setups",
             sent_by_op[CMD_INSERT], sent_by_op[CMD_READ], sent_by_op[CMD_CLEAR],
             sent_by_op[CMD_UNUSED], setups_loaded);
    $display("checked %0d results, %0d reporting an occupied cell, %0d mismatches",
             reports_seen, filled_seen, mismatches);
    if (mismatches == 0) begin
      $display("elevation_grid_min_max_binning test passed");
    end else begin
      $display("elevation_grid_min_max_binning test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/egmmb_pkg.sv
rtl/core/elevation_grid_min_max_binning.sv
rtl/core/egmmb_checker.sv
verif/egmmb_checker.sv
verif/tb_top.sv
